// ===== hdl/i2cm_pkg.sv =====
// Package for the I2C master bit sequencer: request and result structs,
// opcode, command and bus action codes, and sizing constants.
// No dependencies.
package i2cm_pkg;

   localparam int WAIT_WIDTH_DEF    = 16;
   localparam int BITS_PER_BYTE     = 8;
   localparam int PHASE_TICKS_RESET = 5;
   localparam int CSR_ADDR_W        = 3;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_ACK   = 3'd5,
      OP_NACK  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_WAIT       = 3'd0,
      ACT_SCL_REL    = 3'd1,
      ACT_SCL_LOW    = 3'd2,
      ACT_SDA_REL    = 3'd3,
      ACT_SDA_LOW    = 3'd4,
      ACT_SDA_BIT    = 3'd5,
      ACT_SCL_SAMPLE = 3'd6
   } act_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_TICKS = 3'd0;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] wr_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_error;
      logic       rejected;
   } rsp_type;

   function automatic act_type action_of(cmd_type cmd, logic [2:0] step);
      act_type act;
      act = ACT_WAIT;
      case (cmd)
         CMD_START: begin
            case (step)
               3'd0:    act = ACT_SDA_REL;
               3'd1:    act = ACT_SCL_REL;
               3'd3:    act = ACT_SDA_LOW;
               3'd5:    act = ACT_SCL_LOW;
               default: act = ACT_WAIT;
            endcase
         end
         CMD_STOP: begin
            case (step)
               3'd0:    act = ACT_SDA_LOW;
               3'd2:    act = ACT_SCL_REL;
               3'd4:    act = ACT_SDA_REL;
               default: act = ACT_WAIT;
            endcase
         end
         CMD_WRITE: begin
            case (step[1:0])
               2'd0:    act = ACT_SDA_BIT;
               2'd1:    act = ACT_SCL_REL;
               2'd3:    act = ACT_SCL_LOW;
               default: act = ACT_WAIT;
            endcase
         end
         CMD_READ, CMD_ACK, CMD_NACK: begin
            case (step)
               3'd0:    act = ACT_SDA_REL;
               3'd1:    act = ACT_SCL_SAMPLE;
               3'd2:    act = ACT_SCL_LOW;
               default: act = ACT_WAIT;
            endcase
         end
         default: act = ACT_WAIT;
      endcase
      return act;
   endfunction

endpackage

// ===== hdl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: command and tick handling,
// phase timer, APB register and result register. Depends on i2cm_pkg.
// A request is accepted and its result is registered in the result register,
// ready in the following cycle. Throughput: one request per cycle,
// limited only by the single result register draining to the consumer.
// Reset is synchronous and active high; it restores phase_ticks to 5,
// idles the sequencer with both lines released and empties the result register.
module i2c_master_bit_sequencer #(
   parameter int WAIT_WIDTH    = i2cm_pkg::WAIT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  i2cm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output i2cm_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [i2cm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import i2cm_pkg::*;

   localparam int BIT_W = $clog2(BITS_PER_BYTE);
   localparam int LEN_W = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'({WAIT_WIDTH{1'b1}});
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE - 1);

   logic [15:0]           phase_ticks_ff;
   cmd_type               cmd_ff, cmd_in;
   logic [2:0]            step_ff, step_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  ack_ff, ack_in;
   logic [7:0]            hold_ff, hold_in;
   logic                  done_in, rej_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  req_fire;
   logic [LEN_W-1:0]      len_ext;
   logic [WAIT_WIDTH-1:0] phase_len;

   assign pready    = 1'b1;
   assign prdata    = {16'd0, phase_ticks_ff};
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      len_ext = LEN_W'(phase_ticks_ff);
      if (len_ext == '0) begin
         len_ext = LEN_W'(1);
      end
      if (len_ext > LEN_CAP) begin
         len_ext = LEN_CAP;
      end
      phase_len = len_ext[WAIT_WIDTH-1:0];
   end

   // Next state of the sequencer for the request at the input.
   always_comb begin
      logic      start_phase;
      logic      finish;
      logic [WAIT_WIDTH-1:0] wait_dec;
      cmd_in      = cmd_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      wait_in     = wait_ff;
      shift_in    = shift_ff;
      ack_in      = ack_ff;
      hold_in     = hold_ff;
      done_in     = 1'b0;
      rej_in      = 1'b0;
      start_phase = 1'b0;
      finish      = 1'b0;
      wait_dec    = wait_ff;
      if (req_data.op inside {OP_START, OP_STOP, OP_WRITE, OP_READ, OP_ACK, OP_NACK}) begin
         if (cmd_ff != CMD_IDLE) begin
            rej_in = 1'b1;
         end else begin
            cmd_in      = cmd_type'(req_data.op);
            step_in     = 3'd0;
            bit_in      = '0;
            shift_in    = (req_data.op == OP_WRITE) ? req_data.wr_byte : 8'd0;
            start_phase = 1'b1;
         end
      end else if (req_data.op == OP_TICK && cmd_ff != CMD_IDLE) begin
         if (wait_ff != '0) begin
            wait_dec = wait_ff - WAIT_WIDTH'(1);
         end
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            if (action_of(cmd_ff, step_ff) == ACT_SCL_SAMPLE) begin
               if (cmd_ff == CMD_READ) begin
                  shift_in = {shift_ff[6:0], req_data.sda_in};
               end else if (cmd_ff == CMD_ACK) begin
                  ack_in = req_data.sda_in;
               end else begin
                  ack_in = !req_data.sda_in;
               end
            end
            case (cmd_ff)
               CMD_START: begin
                  if (step_ff < 3'd6) step_in = step_ff + 3'd1;
                  else finish = 1'b1;
               end
               CMD_STOP: begin
                  if (step_ff < 3'd5) step_in = step_ff + 3'd1;
                  else finish = 1'b1;
               end
               CMD_WRITE: begin
                  if (step_ff < 3'd3) begin
                     step_in = step_ff + 3'd1;
                  end else if (bit_ff < LAST_BIT) begin
                     bit_in  = bit_ff + BIT_W'(1);
                     step_in = 3'd0;
                  end else begin
                     finish = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (step_ff < 3'd2) begin
                     step_in = step_ff + 3'd1;
                  end else if (bit_ff < LAST_BIT) begin
                     bit_in  = bit_ff + BIT_W'(1);
                     step_in = 3'd1;
                  end else begin
                     finish = 1'b1;
                  end
               end
               CMD_ACK, CMD_NACK: begin
                  if (step_ff < 3'd2) step_in = step_ff + 3'd1;
                  else finish = 1'b1;
               end
               default: finish = 1'b1;
            endcase
            if (finish) begin
               if (cmd_ff == CMD_READ) begin
                  hold_in = shift_in;
               end
               cmd_in  = CMD_IDLE;
               step_in = 3'd0;
               bit_in  = '0;
               done_in = 1'b1;
            end else begin
               start_phase = 1'b1;
            end
         end
      end
      if (start_phase) begin
         wait_in = phase_len;
      end
   end

   // Pin drives for the phase that begins with this request.
   always_comb begin
      act_type act_o;
      logic    begins;
      begins = 1'b0;
      if (req_data.op inside {OP_START, OP_STOP, OP_WRITE, OP_READ, OP_ACK, OP_NACK}) begin
         begins = (cmd_ff == CMD_IDLE);
      end else if (req_data.op == OP_TICK && cmd_ff != CMD_IDLE) begin
         begins = (cmd_in != CMD_IDLE) && (wait_in == phase_len) &&
                  ((wait_ff == '0) || (wait_ff == WAIT_WIDTH'(1)));
      end
      act_o  = begins ? action_of(cmd_in, step_in) : ACT_WAIT;
      scl_in = scl_ff;
      sda_in = sda_ff;
      case (act_o)
         ACT_SCL_REL, ACT_SCL_SAMPLE: scl_in = 1'b0;
         ACT_SCL_LOW:                 scl_in = 1'b1;
         ACT_SDA_REL:                 sda_in = 1'b0;
         ACT_SDA_LOW:                 sda_in = 1'b1;
         ACT_SDA_BIT:                 sda_in = !shift_in[3'(LAST_BIT - bit_in)];
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.scl_low   = scl_in;
      rsp_in.sda_low   = sda_in;
      rsp_in.busy_res  = (cmd_in != CMD_IDLE);
      rsp_in.done_res  = done_in;
      rsp_in.read_data = hold_in;
      rsp_in.ack_error = ack_in;
      rsp_in.rejected  = rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= 16'(PHASE_TICKS_RESET);
      end else if (psel && penable && pwrite && pready &&
                   paddr[CSR_ADDR_W-1:2] == CSR_PHASE_TICKS[CSR_ADDR_W-1:2]) begin
         phase_ticks_ff <= pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_IDLE;
         step_ff      <= 3'd0;
         bit_ff       <= '0;
         wait_ff      <= '0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         ack_ff       <= 1'b0;
         hold_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            cmd_ff   <= cmd_in;
            step_ff  <= step_in;
            bit_ff   <= bit_in;
            wait_ff  <= wait_in;
            shift_ff <= shift_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            hold_ff  <= hold_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while result register is stalled");

   a_busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.busy_res == (cmd_ff != CMD_IDLE)))
      else $error("busy flag disagrees with sequencer state");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("command finished but still busy");

   a_reject_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rejected) |-> !rsp_ff.done_res)
      else $error("rejected request also finished a command");

   a_timer_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff != CMD_IDLE) |-> (wait_ff != '0))
      else $error("active phase has an empty timer");

endmodule

// ===== test/i2c_master_bit_sequencer_tb.sv =====
// Self-checking testbench for the I2C master bit sequencer: drives command and
// tick requests, predicts every result and compares it against the block.
// Depends on i2cm_pkg and i2c_master_bit_sequencer.
module i2c_master_bit_sequencer_tb;
   import i2cm_pkg::*;

   localparam logic [2:0]            OP_SPARE   = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd4;
   localparam int SDA_ZEROS  = 0;
   localparam int SDA_ONES   = 1;
   localparam int SDA_RANDOM = 2;
   localparam int STALL_LIMIT = 1000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   cmd_type     seq_cmd;
   logic [2:0]  seq_step;
   logic [3:0]  seq_bit;
   logic [15:0] seq_wait;
   logic [7:0]  seq_shift;
   logic        seq_scl;
   logic        seq_sda;
   logic        seq_ackerr;
   logic [7:0]  seq_rdhold;
   logic [15:0] seq_phase_ticks;

   rsp_type expected_rsp_q[$];
   rsp_type oldest_rsp;
   int      error_count;
   int      useful_items;
   int      stall_cycles;
   bit      idle_on;

   i2c_master_bit_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void reset_model();
      seq_cmd         = CMD_IDLE;
      seq_step        = '0;
      seq_bit         = '0;
      seq_wait        = '0;
      seq_shift       = '0;
      seq_scl         = 1'b0;
      seq_sda         = 1'b0;
      seq_ackerr      = 1'b0;
      seq_rdhold      = '0;
      seq_phase_ticks = 16'(PHASE_TICKS_RESET);
   endfunction

   function automatic act_type phase_action();
      act_type a;
      a = ACT_WAIT;
      if (seq_cmd == CMD_START) begin
         if (seq_step == 3'd0) a = ACT_SDA_REL;
         else if (seq_step == 3'd1) a = ACT_SCL_REL;
         else if (seq_step == 3'd3) a = ACT_SDA_LOW;
         else if (seq_step == 3'd5) a = ACT_SCL_LOW;
      end else if (seq_cmd == CMD_STOP) begin
         if (seq_step == 3'd0) a = ACT_SDA_LOW;
         else if (seq_step == 3'd2) a = ACT_SCL_REL;
         else if (seq_step == 3'd4) a = ACT_SDA_REL;
      end else if (seq_cmd == CMD_WRITE) begin
         if (seq_step[1:0] == 2'd0) a = ACT_SDA_BIT;
         else if (seq_step[1:0] == 2'd1) a = ACT_SCL_REL;
         else if (seq_step[1:0] == 2'd3) a = ACT_SCL_LOW;
      end else if (seq_cmd == CMD_READ || seq_cmd == CMD_ACK || seq_cmd == CMD_NACK) begin
         if (seq_step == 3'd0) a = ACT_SDA_REL;
         else if (seq_step == 3'd1) a = ACT_SCL_SAMPLE;
         else if (seq_step == 3'd2) a = ACT_SCL_LOW;
      end
      return a;
   endfunction

   function automatic void start_phase();
      case (phase_action())
         ACT_SCL_REL, ACT_SCL_SAMPLE: seq_scl = 1'b0;
         ACT_SCL_LOW:                 seq_scl = 1'b1;
         ACT_SDA_REL:                 seq_sda = 1'b0;
         ACT_SDA_LOW:                 seq_sda = 1'b1;
         ACT_SDA_BIT:                 seq_sda = ~seq_shift[3'd7 - seq_bit[2:0]];
         default:                     ;
      endcase
      seq_wait = (seq_phase_ticks == '0) ? 16'd1 : seq_phase_ticks;
   endfunction

   function automatic bit advance_phase();
      bit finished;
      finished = 1'b0;
      case (seq_cmd)
         CMD_START: begin
            if (seq_step < 3'd6) seq_step = seq_step + 3'd1;
            else finished = 1'b1;
         end
         CMD_STOP: begin
            if (seq_step < 3'd5) seq_step = seq_step + 3'd1;
            else finished = 1'b1;
         end
         CMD_WRITE: begin
            if (seq_step < 3'd3) begin
               seq_step = seq_step + 3'd1;
            end else if (seq_bit < 4'd7) begin
               seq_bit  = seq_bit + 4'd1;
               seq_step = 3'd0;
            end else begin
               finished = 1'b1;
            end
         end
         CMD_READ: begin
            if (seq_step < 3'd2) begin
               seq_step = seq_step + 3'd1;
            end else if (seq_bit < 4'd7) begin
               seq_bit  = seq_bit + 4'd1;
               seq_step = 3'd1;
            end else begin
               finished = 1'b1;
            end
         end
         CMD_ACK, CMD_NACK: begin
            if (seq_step < 3'd2) seq_step = seq_step + 3'd1;
            else finished = 1'b1;
         end
         default: finished = 1'b1;
      endcase
      return finished;
   endfunction

   function automatic rsp_type predict_bus_step(req_type r);
      rsp_type o;
      logic    done_now;
      logic    rej_now;
      done_now = 1'b0;
      rej_now  = 1'b0;
      if (r.op >= OP_START && r.op <= OP_NACK) begin
         if (seq_cmd != CMD_IDLE) begin
            rej_now = 1'b1;
         end else begin
            seq_cmd   = cmd_type'(r.op);
            seq_step  = '0;
            seq_bit   = '0;
            seq_shift = (r.op == OP_WRITE) ? r.wr_byte : 8'h00;
            start_phase();
            useful_items++;
         end
      end else if (r.op == OP_TICK && seq_cmd != CMD_IDLE) begin
         useful_items++;
         if (seq_wait != '0) seq_wait = seq_wait - 16'd1;
         if (seq_wait == '0) begin
            if (phase_action() == ACT_SCL_SAMPLE) begin
               case (seq_cmd)
                  CMD_READ: seq_shift  = {seq_shift[6:0], r.sda_in};
                  CMD_ACK:  seq_ackerr = r.sda_in;
                  default:  seq_ackerr = ~r.sda_in;
               endcase
            end
            if (advance_phase()) begin
               if (seq_cmd == CMD_READ) seq_rdhold = seq_shift;
               seq_cmd  = CMD_IDLE;
               seq_step = '0;
               seq_bit  = '0;
               done_now = 1'b1;
            end else begin
               start_phase();
            end
         end
      end
      o.scl_low   = seq_scl;
      o.sda_low   = seq_sda;
      o.busy_res  = (seq_cmd != CMD_IDLE);
      o.done_res  = done_now;
      o.read_data = seq_rdhold;
      o.ack_error = seq_ackerr;
      o.rejected  = rej_now;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.scl_low !== want.scl_low)
         report_mismatch("scl_low", 32'(got.scl_low), 32'(want.scl_low));
      if (got.sda_low !== want.sda_low)
         report_mismatch("sda_low", 32'(got.sda_low), 32'(want.sda_low));
      if (got.busy_res !== want.busy_res)
         report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
      if (got.done_res !== want.done_res)
         report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
      if (got.ack_error !== want.ack_error)
         report_mismatch("ack_error", 32'(got.ack_error), 32'(want.ack_error));
      if (got.rejected !== want.rejected)
         report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with no request outstanding", 32'(rsp_data), 32'h0);
         end else begin
            oldest_rsp = expected_rsp_q.pop_front();
            check_result(rsp_data, oldest_rsp);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 9) : 0;
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [7:0] data, input logic sda);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = {op, data, sda};
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(predict_bus_step(req_data));
   endtask

   function automatic logic tick_sda(input int mode);
      if (mode == SDA_ZEROS) return 1'b0;
      if (mode == SDA_ONES) return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   // Sends the command, then ticks until it completes; noise_pct percent of the
   // in-between requests are commands or spare codes that the block must ignore.
   task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                              input int sda_mode, input int noise_pct);
      send_request(op, data, 1'($urandom_range(0, 1)));
      while (seq_cmd != CMD_IDLE) begin
         if ($urandom_range(1, 100) <= noise_pct)
            send_request(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         else
            send_request(OP_TICK, 8'($urandom_range(0, 255)), tick_sda(sda_mode));
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_read_check();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = CSR_PHASE_TICKS;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== seq_phase_ticks)
         report_mismatch("phase_ticks read back", prdata, 32'(seq_phase_ticks));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [15:0] value);
      logic [31:0] word;
      word       = $urandom;
      word[15:0] = value;
      drain_results();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = word;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_PHASE_TICKS) seq_phase_ticks = word[15:0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      csr_read_check();
   endtask

   task automatic test_reset_state();
      csr_read_check();
      repeat (3) send_request(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_request(OP_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      run_command(OP_START, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      run_command(OP_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
   endtask

   task automatic test_each_command();
      csr_write(CSR_PHASE_TICKS, 16'd1);
      run_command(OP_START, 8'h00, SDA_RANDOM, 0);
      run_command(OP_WRITE, 8'hFF, SDA_RANDOM, 0);
      run_command(OP_WRITE, 8'h00, SDA_RANDOM, 0);
      run_command(OP_WRITE, 8'hA5, SDA_RANDOM, 30);
      run_command(OP_READ, 8'hFF, SDA_ONES, 0);
      run_command(OP_READ, 8'h00, SDA_ZEROS, 0);
      run_command(OP_READ, 8'h5A, SDA_RANDOM, 20);
      run_command(OP_ACK, 8'h00, SDA_ZEROS, 0);
      run_command(OP_ACK, 8'hFF, SDA_ONES, 0);
      run_command(OP_NACK, 8'h00, SDA_ONES, 0);
      run_command(OP_NACK, 8'hFF, SDA_ZEROS, 0);
      run_command(OP_STOP, 8'h00, SDA_RANDOM, 0);
      send_request(OP_SPARE, 8'hFF, 1'b1);
   endtask

   task automatic test_phase_extremes();
      csr_write(CSR_PHASE_TICKS, 16'd0);
      run_command(OP_START, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      run_command(OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      run_command(OP_ACK, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      run_command(OP_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      csr_write(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      run_command(OP_READ, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      csr_write(CSR_PHASE_TICKS, 16'hFFFF);
      csr_write(CSR_PHASE_TICKS, 16'd12);
      idle_on = 1'b0;
      run_command(OP_NACK, 8'($urandom_range(0, 255)), SDA_RANDOM, 0);
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int target;
      int txn;
      int nbytes;
      target = useful_items + 200;
      txn    = 0;
      while (useful_items < target) begin
         if (txn % 4 == 0)
            csr_write(CSR_PHASE_TICKS,
                      16'(($urandom_range(0, 7) == 0) ? $urandom_range(4, 9)
                                                      : $urandom_range(0, 3)));
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            run_command(OP_START, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
            run_command(OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
            run_command(OP_ACK, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
            nbytes = $urandom_range(1, 3);
            repeat (nbytes) begin
               if ($urandom_range(0, 1)) begin
                  run_command(OP_WRITE, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
                  run_command(OP_ACK, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
               end else begin
                  run_command(OP_READ, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
                  run_command($urandom_range(0, 1) ? OP_ACK : OP_NACK,
                              8'($urandom_range(0, 255)), SDA_RANDOM, 3);
               end
            end
            run_command(OP_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM, 3);
         end else begin
            repeat ($urandom_range(1, 8))
               send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            while (seq_cmd != CMD_IDLE)
               send_request(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         txn++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      idle_on      = 1'b1;
      error_count  = 0;
      useful_items = 0;
      stall_cycles = 0;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_each_command();
      test_phase_extremes();
      test_random_traffic();
      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/i2cm_pkg.sv
hdl/i2c_master_bit_sequencer.sv
test/i2c_master_bit_sequencer_tb.sv
